// ===== hdl/msm_pkg.sv =====
// Shared constants, codes, command and status types for the multi-pattern matcher.
// No dependencies; every other file of the block refers to this package by scoped names.
`timescale 1ns / 1ps
package msm_pkg;

  localparam int NODE_COUNT    = 1024;
  localparam int ALPHABET_SIZE = 128;
  localparam int NODE_W        = $clog2(NODE_COUNT);
  localparam int NODES_W       = NODE_W + 1;
  localparam int SYM_W         = $clog2(ALPHABET_SIZE);
  localparam int OP_W          = 3;
  localparam int CNT_W         = 16;
  localparam int STATUS_W      = 2;
  localparam int TT_AW         = NODE_W + SYM_W;

  typedef logic [OP_W-1:0] op_t;
  localparam op_t OP_PAT_SYM = 3'd0;
  localparam op_t OP_PAT_END = 3'd1;
  localparam op_t OP_BUILD   = 3'd2;
  localparam op_t OP_SCAN    = 3'd3;
  localparam op_t OP_CLEAR   = 3'd4;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_BUILT = 2'd2
  } status_e;

  typedef enum logic [4:0] {
    CMD_NONE, CMD_P_OVF, CMD_P_TT, CMD_P_NODE, CMD_P_DEC,
    CMD_E_RD, CMD_E_WR, CMD_E_OVF,
    CMD_B_INIT, CMD_B_POP, CMD_B_PAR, CMD_B_SL, CMD_B_TT, CMD_B_LINK, CMD_B_SMC,
    CMD_C_RD, CMD_C_NODE, CMD_C_WR, CMD_B_DONE,
    CMD_S_TT, CMD_S_SMC, CMD_S_RES, CMD_S_ERR,
    CMD_CLEAR, CMD_NOP
  } cmd_e;

  typedef struct packed {
    cmd_e step;
    logic publish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic ovf;
    logic built;
    logic queue_empty;
    logic c_last;
    logic out_busy;
  } dp_status_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] a);
    logic [CNT_W:0] s;
    s = {1'b0, a} + {{CNT_W{1'b0}}, 1'b1};
    return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
  endfunction

  function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                                input logic [CNT_W-1:0] b);
    logic [CNT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
  endfunction

endpackage

// ===== hdl/msm_if.sv =====
// Valid/ready channel interfaces for the matcher's input items and result items.
// Depends on msm_pkg for the field widths.
`timescale 1ns / 1ps
interface msm_in_if;
  logic                       valid;
  logic                       ready;
  logic [msm_pkg::OP_W-1:0]   operation;
  logic [msm_pkg::SYM_W-1:0]  symbol;
  modport source (output valid, operation, symbol, input ready);
  modport sink   (input valid, operation, symbol, output ready);
endinterface

interface msm_out_if;
  logic                          valid;
  logic                          ready;
  logic [msm_pkg::CNT_W-1:0]     match_count;
  logic [msm_pkg::NODE_W-1:0]    state_node;
  logic [msm_pkg::STATUS_W-1:0]  status;
  modport source (output valid, match_count, state_node, status, input ready);
  modport sink   (input valid, match_count, state_node, status, output ready);
endinterface

// ===== hdl/msm_ctrl.sv =====
// Sequencing state machine of the matcher: issues at most one datapath command per cycle, none while idle.
// Depends on msm_pkg for the command and status types and the operation codes.
`timescale 1ns / 1ps
module msm_ctrl (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  input  logic [msm_pkg::OP_W-1:0] in_op_i,
  output logic                     in_ready_o,
  input  msm_pkg::dp_status_t      status_i,
  output msm_pkg::ctrl_cmd_t       cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE, S_P_OVF, S_P_TT, S_P_NODE, S_P_DEC,
    S_E_RD, S_E_WR, S_E_OVF,
    S_B_INIT, S_B_CHK, S_B_POP, S_B_PAR, S_B_SL, S_B_TT, S_B_LINK, S_B_SMC,
    S_C_RD, S_C_NODE, S_C_WR, S_B_DONE,
    S_S_TT, S_S_SMC, S_S_RES, S_S_ERR,
    S_CLR, S_NOP, S_PUB
  } state_e;

  state_e        state_q, state_d;
  msm_pkg::cmd_e cmd_q;

  function automatic msm_pkg::cmd_e cmd_of(input state_e s);
    msm_pkg::cmd_e c;
    case (s)
      S_P_OVF:  c = msm_pkg::CMD_P_OVF;
      S_P_TT:   c = msm_pkg::CMD_P_TT;
      S_P_NODE: c = msm_pkg::CMD_P_NODE;
      S_P_DEC:  c = msm_pkg::CMD_P_DEC;
      S_E_RD:   c = msm_pkg::CMD_E_RD;
      S_E_WR:   c = msm_pkg::CMD_E_WR;
      S_E_OVF:  c = msm_pkg::CMD_E_OVF;
      S_B_INIT: c = msm_pkg::CMD_B_INIT;
      S_B_POP:  c = msm_pkg::CMD_B_POP;
      S_B_PAR:  c = msm_pkg::CMD_B_PAR;
      S_B_SL:   c = msm_pkg::CMD_B_SL;
      S_B_TT:   c = msm_pkg::CMD_B_TT;
      S_B_LINK: c = msm_pkg::CMD_B_LINK;
      S_B_SMC:  c = msm_pkg::CMD_B_SMC;
      S_C_RD:   c = msm_pkg::CMD_C_RD;
      S_C_NODE: c = msm_pkg::CMD_C_NODE;
      S_C_WR:   c = msm_pkg::CMD_C_WR;
      S_B_DONE: c = msm_pkg::CMD_B_DONE;
      S_S_TT:   c = msm_pkg::CMD_S_TT;
      S_S_SMC:  c = msm_pkg::CMD_S_SMC;
      S_S_RES:  c = msm_pkg::CMD_S_RES;
      S_S_ERR:  c = msm_pkg::CMD_S_ERR;
      S_CLR:    c = msm_pkg::CMD_CLEAR;
      S_NOP:    c = msm_pkg::CMD_NOP;
      default:  c = msm_pkg::CMD_NONE;
    endcase
    return c;
  endfunction

  assign in_ready_o    = (state_q == S_IDLE);
  assign cmd_o.step    = cmd_q;
  assign cmd_o.publish = (state_q == S_PUB) && !status_i.out_busy;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          case (in_op_i)
            msm_pkg::OP_PAT_SYM: state_d = status_i.ovf ? S_P_OVF : S_P_TT;
            msm_pkg::OP_PAT_END: state_d = status_i.ovf ? S_E_OVF : S_E_RD;
            msm_pkg::OP_BUILD:   state_d = S_B_INIT;
            msm_pkg::OP_SCAN:    state_d = status_i.built ? S_S_TT : S_S_ERR;
            msm_pkg::OP_CLEAR:   state_d = S_CLR;
            default:             state_d = S_NOP;
          endcase
        end
      end
      S_P_TT:   state_d = S_P_NODE;
      S_P_NODE: state_d = S_P_DEC;
      S_E_RD:   state_d = S_E_WR;
      S_B_INIT: state_d = S_B_CHK;
      S_B_CHK:  state_d = status_i.queue_empty ? S_B_DONE : S_B_POP;
      S_B_POP:  state_d = S_B_PAR;
      S_B_PAR:  state_d = S_B_SL;
      S_B_SL:   state_d = S_B_TT;
      S_B_TT:   state_d = S_B_LINK;
      S_B_LINK: state_d = S_B_SMC;
      S_B_SMC:  state_d = S_C_RD;
      S_C_RD:   state_d = S_C_NODE;
      S_C_NODE: state_d = S_C_WR;
      S_C_WR:   state_d = status_i.c_last ? S_B_CHK : S_C_RD;
      S_S_TT:   state_d = S_S_SMC;
      S_S_SMC:  state_d = S_S_RES;
      S_PUB:    state_d = status_i.out_busy ? S_PUB : S_IDLE;
      S_P_OVF, S_P_DEC, S_E_WR, S_E_OVF, S_B_DONE,
      S_S_RES, S_S_ERR, S_CLR, S_NOP: state_d = S_PUB;
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cmd_q   <= msm_pkg::CMD_NONE;
    end else begin
      state_q <= state_d;
      cmd_q   <= cmd_of(state_d);
    end
  end

endmodule

// ===== hdl/msm_datapath.sv =====
// Datapath of the matcher: trie and automaton memories, cursors, queue pointers
// and the result register. Executes the commands of msm_ctrl; depends on msm_pkg.
`timescale 1ns / 1ps
module msm_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_accept_i,
  input  logic [msm_pkg::OP_W-1:0]      in_op_i,
  input  logic [msm_pkg::SYM_W-1:0]     in_symbol_i,
  input  msm_pkg::ctrl_cmd_t            cmd_i,
  output msm_pkg::dp_status_t           status_o,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic [msm_pkg::CNT_W-1:0]     out_count_o,
  output logic [msm_pkg::NODE_W-1:0]    out_node_o,
  output logic [msm_pkg::STATUS_W-1:0]  out_status_o
);

  localparam int NW = msm_pkg::NODE_W;
  localparam int SW = msm_pkg::SYM_W;
  localparam int CW = msm_pkg::CNT_W;
  localparam int UW = msm_pkg::NODES_W;
  localparam int AW = msm_pkg::TT_AW;
  localparam logic [UW-1:0] NODE_LIMIT = UW'(msm_pkg::NODE_COUNT);

  // Memories: transition table, node records, suffix data and the breadth-first queue.
  logic [NW-1:0] tt_mem   [2**AW];
  logic [NW-1:0] par_mem  [2**NW];
  logic [SW-1:0] isym_mem [2**NW];
  logic [NW-1:0] sl_mem   [2**NW];
  logic [CW-1:0] pend_mem [2**NW];
  logic [CW-1:0] smc_mem  [2**NW];
  logic [NW-1:0] q_mem    [2**NW];

  logic [NW-1:0] tt_rd0_q, tt_rd1_q, par_rd_q, sl_rd_q, q_rd_q;
  logic [SW-1:0] isym_rd_q;
  logic [CW-1:0] pend_rd_q, smc_rd_q;

  logic          tt_we, tt_re0, tt_re1, node_we, node_re, sl_we, sl_re;
  logic          pend_we, pend_re, smc_we, smc_re, q_we, q_re;
  logic [AW-1:0] tt_waddr, tt_raddr0, tt_raddr1;
  logic [NW-1:0] tt_wdata, node_waddr, node_raddr, par_wdata, sl_waddr, sl_raddr;
  logic [NW-1:0] pend_waddr, pend_raddr, smc_waddr, smc_raddr, q_waddr, q_raddr, q_wdata;
  logic [SW-1:0] isym_wdata;
  logic [CW-1:0] pend_wdata, smc_wdata;

  // Control state.
  logic [UW-1:0] nodes_used_q, head_q, tail_q;
  logic [NW-1:0] ins_q, scan_q;
  logic          built_q, ovf_q, out_valid_q;
  logic [CW-1:0] root_pend_q;

  // Working registers.
  logic [SW-1:0] sym_q, c_q;
  logic [NW-1:0] u_q, link_q, res_node_q;
  logic [CW-1:0] res_cnt_q;
  msm_pkg::status_e res_status_q;

  logic [NW-1:0] cmp_node, link_d, new_node;
  logic [SW-1:0] cmp_sym;
  logic [CW-1:0] pend_val, pend_node_val;
  logic          child, full;

  assign new_node = nodes_used_q[NW-1:0];
  assign full     = (nodes_used_q == NODE_LIMIT);
  assign cmp_node = (cmd_i.step == msm_pkg::CMD_C_WR) ? u_q : ins_q;
  assign cmp_sym  = (cmd_i.step == msm_pkg::CMD_C_WR) ? c_q : sym_q;
  // A table entry is a true trie child only if its node record points back at it.
  assign child    = (tt_rd0_q != '0) && ({1'b0, tt_rd0_q} < nodes_used_q) &&
                    (par_rd_q == cmp_node) && (isym_rd_q == cmp_sym);
  assign link_d   = ((u_q == '0) || (par_rd_q == '0)) ? '0 : tt_rd0_q;
  assign pend_node_val = (cmd_i.step == msm_pkg::CMD_E_WR) ? ins_q : u_q;
  assign pend_val = (pend_node_val == '0) ? root_pend_q : pend_rd_q;

  always_comb begin
    tt_we = 1'b0; tt_waddr = '0; tt_wdata = '0;
    tt_re0 = 1'b0; tt_raddr0 = '0; tt_re1 = 1'b0; tt_raddr1 = '0;
    node_we = 1'b0; node_waddr = '0; par_wdata = '0; isym_wdata = '0;
    node_re = 1'b0; node_raddr = '0;
    sl_we = 1'b0; sl_waddr = '0; sl_re = 1'b0; sl_raddr = '0;
    pend_we = 1'b0; pend_waddr = '0; pend_wdata = '0; pend_re = 1'b0; pend_raddr = '0;
    smc_we = 1'b0; smc_waddr = '0; smc_wdata = '0; smc_re = 1'b0; smc_raddr = '0;
    q_we = 1'b0; q_waddr = '0; q_wdata = '0; q_re = 1'b0; q_raddr = '0;
    case (cmd_i.step)
      msm_pkg::CMD_P_TT: begin
        tt_re0 = 1'b1; tt_raddr0 = {ins_q, sym_q};
      end
      msm_pkg::CMD_P_NODE, msm_pkg::CMD_C_NODE: begin
        node_re = 1'b1; node_raddr = tt_rd0_q;
      end
      msm_pkg::CMD_P_DEC: begin
        // The branches follow the same order as the cursor update below, so an
        // entry that was never written counts as no child in both places.
        if (child) begin
          // An existing child needs no new node.
        end else if (!full) begin
          node_we = 1'b1; node_waddr = new_node; par_wdata = ins_q; isym_wdata = sym_q;
          pend_we = 1'b1; pend_waddr = new_node; pend_wdata = '0;
          tt_we = 1'b1; tt_waddr = {ins_q, sym_q}; tt_wdata = new_node;
        end
      end
      msm_pkg::CMD_E_RD: begin
        pend_re = 1'b1; pend_raddr = ins_q;
      end
      msm_pkg::CMD_E_WR: begin
        if (ins_q != '0) begin
          pend_we = 1'b1; pend_waddr = ins_q; pend_wdata = msm_pkg::sat_inc(pend_rd_q);
        end
      end
      msm_pkg::CMD_B_INIT: begin
        q_we = 1'b1; q_waddr = '0; q_wdata = '0;
      end
      msm_pkg::CMD_B_POP: begin
        q_re = 1'b1; q_raddr = head_q[NW-1:0];
      end
      msm_pkg::CMD_B_PAR: begin
        node_re = 1'b1; node_raddr = q_rd_q;
      end
      msm_pkg::CMD_B_SL: begin
        sl_re = 1'b1; sl_raddr = par_rd_q;
      end
      msm_pkg::CMD_B_TT: begin
        tt_re0 = 1'b1; tt_raddr0 = {sl_rd_q, isym_rd_q};
      end
      msm_pkg::CMD_B_LINK: begin
        sl_we = 1'b1; sl_waddr = u_q;
        pend_re = 1'b1; pend_raddr = u_q;
        smc_re = 1'b1; smc_raddr = link_d;
      end
      msm_pkg::CMD_B_SMC: begin
        smc_we = 1'b1; smc_waddr = u_q;
        smc_wdata = (u_q == '0) ? pend_val : msm_pkg::sat_add(pend_val, smc_rd_q);
      end
      msm_pkg::CMD_C_RD: begin
        tt_re0 = 1'b1; tt_raddr0 = {u_q, c_q};
        tt_re1 = 1'b1; tt_raddr1 = {link_q, c_q};
      end
      msm_pkg::CMD_C_WR: begin
        if (child) begin
          if (tail_q < NODE_LIMIT) begin
            q_we = 1'b1; q_waddr = tail_q[NW-1:0]; q_wdata = tt_rd0_q;
          end
        end else begin
          tt_we = 1'b1; tt_waddr = {u_q, c_q};
          tt_wdata = (u_q == '0) ? '0 : tt_rd1_q;
        end
      end
      msm_pkg::CMD_S_TT: begin
        tt_re0 = 1'b1; tt_raddr0 = {scan_q, sym_q};
      end
      msm_pkg::CMD_S_SMC: begin
        smc_re = 1'b1; smc_raddr = tt_rd0_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (tt_we) tt_mem[tt_waddr] <= tt_wdata;
    if (tt_re0) tt_rd0_q <= tt_mem[tt_raddr0];
    if (tt_re1) tt_rd1_q <= tt_mem[tt_raddr1];
  end

  always_ff @(posedge clk_i) begin
    if (node_we) begin
      par_mem[node_waddr]  <= par_wdata;
      isym_mem[node_waddr] <= isym_wdata;
    end
    if (node_re) begin
      par_rd_q  <= par_mem[node_raddr];
      isym_rd_q <= isym_mem[node_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (sl_we) sl_mem[sl_waddr] <= link_d;
    if (sl_re) sl_rd_q <= sl_mem[sl_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (pend_we) pend_mem[pend_waddr] <= pend_wdata;
    if (pend_re) pend_rd_q <= pend_mem[pend_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (smc_we) smc_mem[smc_waddr] <= smc_wdata;
    if (smc_re) smc_rd_q <= smc_mem[smc_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (q_we) q_mem[q_waddr] <= q_wdata;
    if (q_re) q_rd_q <= q_mem[q_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nodes_used_q <= UW'(1);
      ins_q        <= '0;
      scan_q       <= '0;
      built_q      <= 1'b0;
      ovf_q        <= 1'b0;
      root_pend_q  <= '0;
      head_q       <= '0;
      tail_q       <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (in_accept_i &&
          ((in_op_i == msm_pkg::OP_PAT_SYM) || (in_op_i == msm_pkg::OP_PAT_END))) begin
        built_q <= 1'b0;
      end
      case (cmd_i.step)
        msm_pkg::CMD_P_DEC: begin
          if (child) begin
            ins_q <= tt_rd0_q;
          end else if (full) begin
            ovf_q <= 1'b1;
          end else begin
            nodes_used_q <= nodes_used_q + UW'(1);
            ins_q        <= new_node;
          end
        end
        msm_pkg::CMD_E_WR: begin
          if (ins_q == '0) root_pend_q <= msm_pkg::sat_inc(root_pend_q);
          ins_q <= '0;
        end
        msm_pkg::CMD_E_OVF: begin
          ovf_q <= 1'b0;
          ins_q <= '0;
        end
        msm_pkg::CMD_B_INIT: begin
          head_q <= '0;
          tail_q <= UW'(1);
        end
        msm_pkg::CMD_B_POP: head_q <= head_q + UW'(1);
        msm_pkg::CMD_C_WR: begin
          if (child && (tail_q < NODE_LIMIT)) tail_q <= tail_q + UW'(1);
        end
        msm_pkg::CMD_B_DONE: begin
          built_q <= 1'b1;
          scan_q  <= '0;
        end
        msm_pkg::CMD_S_SMC: scan_q <= tt_rd0_q;
        msm_pkg::CMD_CLEAR: begin
          nodes_used_q <= UW'(1);
          ins_q        <= '0;
          scan_q       <= '0;
          built_q      <= 1'b0;
          ovf_q        <= 1'b0;
          root_pend_q  <= '0;
        end
        default: ;
      endcase
      if (cmd_i.publish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept_i) sym_q <= in_symbol_i;
    case (cmd_i.step)
      msm_pkg::CMD_P_OVF: begin
        res_status_q <= msm_pkg::ST_FULL; res_node_q <= ins_q; res_cnt_q <= '0;
      end
      msm_pkg::CMD_P_DEC: begin
        res_cnt_q <= '0;
        if (child) begin
          res_status_q <= msm_pkg::ST_OK; res_node_q <= tt_rd0_q;
        end else if (full) begin
          res_status_q <= msm_pkg::ST_FULL; res_node_q <= ins_q;
        end else begin
          res_status_q <= msm_pkg::ST_OK; res_node_q <= new_node;
        end
      end
      msm_pkg::CMD_E_WR, msm_pkg::CMD_B_DONE, msm_pkg::CMD_CLEAR: begin
        res_status_q <= msm_pkg::ST_OK; res_node_q <= '0; res_cnt_q <= '0;
      end
      msm_pkg::CMD_E_OVF: begin
        res_status_q <= msm_pkg::ST_FULL; res_node_q <= '0; res_cnt_q <= '0;
      end
      msm_pkg::CMD_B_PAR:  u_q <= q_rd_q;
      msm_pkg::CMD_B_LINK: link_q <= link_d;
      msm_pkg::CMD_B_SMC:  c_q <= '0;
      msm_pkg::CMD_C_WR:   c_q <= c_q + SW'(1);
      msm_pkg::CMD_S_RES: begin
        res_status_q <= msm_pkg::ST_OK; res_node_q <= scan_q; res_cnt_q <= smc_rd_q;
      end
      msm_pkg::CMD_S_ERR: begin
        res_status_q <= msm_pkg::ST_NOT_BUILT; res_node_q <= scan_q; res_cnt_q <= '0;
      end
      msm_pkg::CMD_NOP: begin
        res_status_q <= msm_pkg::ST_OK; res_node_q <= scan_q; res_cnt_q <= '0;
      end
      default: ;
    endcase
    if (cmd_i.publish) begin
      out_count_o  <= res_cnt_q;
      out_node_o   <= res_node_q;
      out_status_o <= res_status_q;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign status_o.ovf         = ovf_q;
  assign status_o.built       = built_q;
  assign status_o.queue_empty = (head_q == tail_q);
  assign status_o.c_last      = (c_q == SW'(msm_pkg::ALPHABET_SIZE - 1));
  assign status_o.out_busy    = out_valid_q && !out_ready_i;

  a_nodes_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (nodes_used_q != '0) && (nodes_used_q <= NODE_LIMIT))
    else $error("node count out of range");
  a_cursor_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, ins_q} < nodes_used_q)
    else $error("insert cursor beyond the allocated nodes");
  a_queue_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (head_q <= tail_q) && (tail_q <= NODE_LIMIT))
    else $error("breadth-first queue pointers inconsistent");
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.publish |-> !(out_valid_q && !out_ready_i))
    else $error("result overwritten while still waiting");

endmodule

// ===== hdl/multi_pattern_string_matcher_core.sv =====
// Top level of the Aho-Corasick multi-pattern matcher over seven-bit symbols.
// Depends on msm_pkg, the interfaces in msm_if.sv, msm_ctrl and msm_datapath.
`timescale 1ns / 1ps
//
//   Channel  Dir  Fields                                   Transfer when
//   in_i     in   operation[2:0], symbol[6:0]              valid && ready
//   out_o    out  match_count[15:0], state_node[9:0],
//                 status[1:0]                              valid && ready
//
// One item is worked on at a time. A pattern symbol reads its transition entry, then the
// node record it names, then decides; a pattern end reads and then writes the end count;
// a scan reads the transition, then the match count; each memory read is synchronous.
// A build walks the trie breadth first and visits all 128 transition entries of every node.
// Reset is asynchronous and active low and needs no clearing pass; the node count
// marks which table rows are live. A stalled result waits in the output register and
// holds the block only once the next result is ready to publish; input ready is high
// only while idle.
module multi_pattern_string_matcher_core (
  input  logic      clk_i,
  input  logic      rst_ni,
  msm_in_if.sink    in_i,
  msm_out_if.source out_o
);

  msm_pkg::ctrl_cmd_t  cmd;
  msm_pkg::dp_status_t dp_status;
  logic                in_ready;

  // The controller sequences every operation; the datapath holds the memories, cursors and result.
  msm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_op_i    (in_i.operation),
    .in_ready_o (in_ready),
    .status_i   (dp_status),
    .cmd_o      (cmd)
  );

  assign in_i.ready = in_ready;

  // The datapath captures the symbol on each input transfer and owns the result
  // register, so a finished result is shown until the sink takes it.
  msm_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_accept_i  (in_i.valid && in_ready),
    .in_op_i      (in_i.operation),
    .in_symbol_i  (in_i.symbol),
    .cmd_i        (cmd),
    .status_o     (dp_status),
    .out_ready_i  (out_o.ready),
    .out_valid_o  (out_o.valid),
    .out_count_o  (out_o.match_count),
    .out_node_o   (out_o.state_node),
    .out_status_o (out_o.status)
  );

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the Aho-Corasick multi-pattern matcher core.
// Depends on msm_pkg and on the channel interfaces in hdl/msm_if.sv.
`timescale 1ns / 1ps

module testbench;

  localparam int WATCHDOG_LIMIT = 200000;
  localparam int TRAIL_CYCLES   = 40;
  localparam int HOLD_CYCLES    = 400;
  localparam int NW             = msm_pkg::NODE_W;
  localparam int SW             = msm_pkg::SYM_W;
  localparam int CW             = msm_pkg::CNT_W;
  localparam int NODES          = msm_pkg::NODE_COUNT;
  localparam int ALPHA          = msm_pkg::ALPHABET_SIZE;

  typedef struct packed {
    logic [CW-1:0]    match_count;
    logic [NW-1:0]    state_node;
    msm_pkg::status_e status;
  } match_result_t;

  // Scoreboard that keeps its own copy of the automaton. The expected result of each
  // accepted item is computed when that item transfers and waits in a queue.
  class match_scoreboard;
    logic [NW-1:0] next_node [NODES*ALPHA];
    logic [NW-1:0] parent [NODES];
    logic [SW-1:0] via_sym [NODES];
    logic [NW-1:0] fail_link [NODES];
    logic [CW-1:0] end_count [NODES];
    logic [CW-1:0] hit_count [NODES];
    int            walk_order [NODES];
    int            nodes_used;
    int            load_pos;
    int            text_pos;
    bit            built;
    bit            overflow;
    match_result_t pending_results [$];
    int            errors;
    int            results_seen;

    function new();
      errors = 0;
      results_seen = 0;
      wipe();
    endfunction

    function void wipe();
      foreach (next_node[i]) next_node[i] = '0;
      for (int n = 0; n < NODES; n++) begin
        parent[n] = '0;
        via_sym[n] = '0;
        fail_link[n] = '0;
        end_count[n] = '0;
        hit_count[n] = '0;
      end
      nodes_used = 1;
      load_pos = 0;
      text_pos = 0;
      built = 0;
      overflow = 0;
    endfunction

    function int edge_of(int n, int c);
      return next_node[n*ALPHA + c];
    endfunction

    function bit has_child(int n, int c);
      int t;
      t = edge_of(n, c);
      return t != 0 && t < nodes_used && parent[t] == n && via_sym[t] == c;
    endfunction

    function logic [CW-1:0] add_sat(logic [CW-1:0] a, logic [CW-1:0] b);
      int s;
      s = int'(a) + int'(b);
      return (s > 65535) ? 16'hFFFF : s[CW-1:0];
    endfunction

    // Breadth-first walk: suffix links, completed transitions and match counts.
    function void compile_automaton();
      int head, tail, u, lnk;
      head = 0;
      tail = 0;
      walk_order[tail++] = 0;
      while (head < tail) begin
        u = walk_order[head++];
        if (u == 0 || parent[u] == 0) lnk = 0;
        else lnk = edge_of(fail_link[parent[u]], via_sym[u]);
        fail_link[u] = NW'(lnk);
        if (u == 0) hit_count[u] = end_count[u];
        else hit_count[u] = add_sat(end_count[u], hit_count[fail_link[u]]);
        for (int c = 0; c < ALPHA; c++) begin
          if (has_child(u, c)) begin
            if (tail < NODES) walk_order[tail++] = edge_of(u, c);
          end else begin
            next_node[u*ALPHA + c] = NW'((u == 0) ? 0 : edge_of(fail_link[u], c));
          end
        end
      end
      built = 1;
      text_pos = 0;
    endfunction

    function void note_input(msm_pkg::op_t op, logic [SW-1:0] sym);
      match_result_t r;
      int v;
      r.match_count = '0;
      r.status = msm_pkg::ST_OK;
      case (op)
        msm_pkg::OP_PAT_SYM: begin
          built = 0;
          if (overflow) begin
            r.status = msm_pkg::ST_FULL;
          end else if (has_child(load_pos, sym)) begin
            load_pos = edge_of(load_pos, sym);
          end else if (nodes_used >= NODES) begin
            overflow = 1;
            r.status = msm_pkg::ST_FULL;
          end else begin
            v = nodes_used++;
            parent[v] = NW'(load_pos);
            via_sym[v] = sym;
            for (int c = 0; c < ALPHA; c++) next_node[v*ALPHA + c] = '0;
            next_node[load_pos*ALPHA + sym] = NW'(v);
            load_pos = v;
          end
          r.state_node = NW'(load_pos);
        end
        msm_pkg::OP_PAT_END: begin
          built = 0;
          if (overflow) begin
            r.status = msm_pkg::ST_FULL;
            overflow = 0;
          end else begin
            end_count[load_pos] = add_sat(end_count[load_pos], 16'd1);
          end
          load_pos = 0;
          r.state_node = '0;
        end
        msm_pkg::OP_BUILD: begin
          compile_automaton();
          r.state_node = NW'(text_pos);
        end
        msm_pkg::OP_SCAN: begin
          if (!built) begin
            r.status = msm_pkg::ST_NOT_BUILT;
          end else begin
            text_pos = edge_of(text_pos, sym);
            r.match_count = hit_count[text_pos];
          end
          r.state_node = NW'(text_pos);
        end
        msm_pkg::OP_CLEAR: begin
          wipe();
          r.state_node = '0;
        end
        default: r.state_node = NW'(text_pos);
      endcase
      pending_results.insert(pending_results.size(), r);
    endfunction

    function void check_result(logic [CW-1:0] cnt, logic [NW-1:0] node,
                               logic [msm_pkg::STATUS_W-1:0] st);
      match_result_t e;
      results_seen++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result count=%0d node=%0d status=%0d",
                 $time, cnt, node, st);
        errors++;
        return;
      end
      e = pending_results.pop_front();
      if (cnt !== e.match_count) begin
        $display("%0t: match_count expected %0d actual %0d", $time, e.match_count, cnt);
        errors++;
      end
      if (node !== e.state_node) begin
        $display("%0t: state_node expected %0d actual %0d", $time, e.state_node, node);
        errors++;
      end
      if (st !== e.status) begin
        $display("%0t: status expected %0d actual %0d", $time, e.status, st);
        errors++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  msm_in_if  in_if ();
  msm_out_if out_if ();

  multi_pattern_string_matcher_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  match_scoreboard sb;
  bit calm;      // when set, neither side inserts random idle cycles
  bit hold_done;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Offers one item and returns at the edge where it transfers. Valid is left high,
  // so a following item with no gap goes out back to back.
  task automatic send_item(msm_pkg::op_t op, logic [SW-1:0] sym);
    int gap;
    gap = calm ? 0 : $urandom_range(8);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.operation <= op;
    in_if.symbol <= sym;
    do @(posedge clk_i); while (!in_if.ready);
    sb.note_input(op, sym);
  endtask

  task automatic load_pattern(logic [SW-1:0] syms [$]);
    foreach (syms[i]) send_item(msm_pkg::OP_PAT_SYM, syms[i]);
    send_item(msm_pkg::OP_PAT_END, '0);
  endtask

  // Result side: random stalls, one long hold-off once traffic is under way so that
  // the output register fills and the block refuses further input transfers.
  initial begin
    int stall;
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (!hold_done && sb.results_seen >= 150) begin
        hold_done = 1;
        stall = HOLD_CYCLES;
      end else begin
        stall = calm ? 0 : $urandom_range(8);
      end
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!out_if.valid);
      sb.check_result(out_if.match_count, out_if.state_node, out_if.status);
    end
  end

  // Any stretch without a single transfer beyond the longest build ends the run.
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk_i);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) quiet = 0;
      else quiet++;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    logic [SW-1:0] pat [$];
    logic [SW-1:0] letters [3];
    int sent, npat, plen, nscan;

    sb = new();
    calm = 0;
    hold_done = 0;
    in_if.valid = 1'b0;
    in_if.operation = msm_pkg::OP_PAT_SYM;
    in_if.symbol = '0;
    rst_ni = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: scan before build, unused codes, empty pattern, the classic
    // overlapping pattern set, extreme symbols, loading after a build, clear.
    send_item(msm_pkg::OP_SCAN, 7'd0);
    send_item(msm_pkg::op_t'(5), 7'd127);
    send_item(msm_pkg::op_t'(6), 7'd85);
    send_item(msm_pkg::op_t'(7), 7'd42);
    send_item(msm_pkg::OP_PAT_END, '0);
    load_pattern('{7'd104, 7'd101});
    load_pattern('{7'd115, 7'd104, 7'd101});
    load_pattern('{7'd104, 7'd105, 7'd115});
    load_pattern('{7'd0, 7'd127});
    send_item(msm_pkg::OP_BUILD, '0);
    send_item(msm_pkg::OP_SCAN, 7'd115);
    send_item(msm_pkg::OP_SCAN, 7'd104);
    send_item(msm_pkg::OP_SCAN, 7'd101);
    send_item(msm_pkg::OP_SCAN, 7'd0);
    send_item(msm_pkg::OP_SCAN, 7'd127);
    send_item(msm_pkg::OP_PAT_SYM, 7'd127);
    send_item(msm_pkg::OP_SCAN, 7'd104);
    send_item(msm_pkg::OP_BUILD, '0);
    send_item(msm_pkg::OP_SCAN, 7'd104);
    send_item(msm_pkg::OP_CLEAR, '0);

    // Random sessions: load a few patterns over a small alphabet so that they share
    // prefixes and suffixes, usually build, then scan text mostly over the same letters.
    sent = 0;
    while (sent < 470) begin
      calm = ($urandom_range(4) == 0);
      if (sb.nodes_used > 100 || $urandom_range(3) == 0) begin
        send_item(msm_pkg::OP_CLEAR, '0);
        sent++;
      end
      foreach (letters[i]) letters[i] = 7'($urandom_range(127));
      npat = $urandom_range(6, 1);
      for (int p = 0; p < npat; p++) begin
        pat.delete();
        plen = $urandom_range(5);
        for (int k = 0; k < plen; k++) begin
          if ($urandom_range(9) == 0) pat.insert(pat.size(), 7'($urandom_range(127)));
          else pat.insert(pat.size(), letters[$urandom_range(2)]);
        end
        load_pattern(pat);
        sent += plen + 1;
      end
      if ($urandom_range(7) != 0) begin
        send_item(msm_pkg::OP_BUILD, '0);
        sent++;
      end
      nscan = $urandom_range(40, 10);
      for (int k = 0; k < nscan; k++) begin
        if ($urandom_range(29) == 0) send_item(msm_pkg::op_t'($urandom_range(7, 5)),
                                               7'($urandom_range(127)));
        else if ($urandom_range(9) == 0) send_item(msm_pkg::OP_SCAN,
                                                   7'($urandom_range(127)));
        else send_item(msm_pkg::OP_SCAN, letters[$urandom_range(2)]);
        sent++;
      end
    end
    in_if.valid <= 1'b0;

    while (sb.pending_results.size() != 0) @(posedge clk_i);
    repeat (TRAIL_CYCLES) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
